// ----- rtl/mbpt_pkg.sv -----
// ---------------------------------------------------------------------------
// mbpt_pkg
// Shared widths, constants and codes for the masked byte pattern trigger.
// ---------------------------------------------------------------------------
package mbpt_pkg;

	localparam int unsigned PATTERN_MAX   = 8;
	localparam int unsigned TEXT_LOOKBACK = 64;
	localparam int unsigned HEX_LOOKBACK  = 32;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned HIST_W    = PATTERN_MAX * BYTE_W;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned FILL_W    = 4;
	localparam int unsigned AGE_W     = 7;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 64;

	localparam logic [AGE_W-1:0]  AGE_MAX      = '1;
	localparam logic [AGE_W-1:0]  TEXT_LB      = AGE_W'(TEXT_LOOKBACK);
	localparam logic [AGE_W-1:0]  HEX_LB       = AGE_W'(HEX_LOOKBACK);
	localparam logic [FILL_W-1:0] FILL_MAX     = FILL_W'(PATTERN_MAX);
	localparam logic [TICK_W-1:0] TICK_MAX     = '1;

	localparam logic [CFG_DAT_W-1:0] PATTERN_RST = '0;
	localparam logic [PATTERN_MAX-1:0] CARE_RST  = '1;
	localparam logic [LEN_W-1:0]  LEN_RST        = LEN_W'(1);
	localparam logic [TICK_W-1:0] COOLDOWN_RST   = TICK_W'(20);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN  = 3'd0,
		REG_CARE     = 3'd1,
		REG_LENGTH   = 3'd2,
		REG_HEX      = 3'd3,
		REG_COOLDOWN = 3'd4
	} cfg_reg_t;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

endpackage

// ----- rtl/mbpt_in_if.sv -----
// ---------------------------------------------------------------------------
// mbpt_in_if
// Request channel: received byte or millisecond tick, valid/ready.
// ---------------------------------------------------------------------------
interface mbpt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [mbpt_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- rtl/mbpt_out_if.sv -----
// ---------------------------------------------------------------------------
// mbpt_out_if
// Result channel: pattern seen and fire flags, valid/ready.
// ---------------------------------------------------------------------------
interface mbpt_out_if;
	logic valid;
	logic ready;
	logic pattern_seen;
	logic fire;

	modport source (output valid, output pattern_seen, output fire, input ready);
	modport sink   (input valid, input pattern_seen, input fire, output ready);
endinterface

// ----- rtl/masked_byte_pattern_trigger.sv -----
// ---------------------------------------------------------------------------
// masked_byte_pattern_trigger
// Masked byte pattern match over the last eight bytes with lookback window
// and fire cooldown counted in millisecond ticks.
// ---------------------------------------------------------------------------
// The result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while out_ch is ready; the result register frees as it is taken.
// The match, window and cooldown logic sits between state and result register.
// Reset: config registers to defaults, history empty, no match pending,
// tick counter saturated so the first match may fire at once.
module masked_byte_pattern_trigger (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbpt_pkg::CFG_DAT_W-1:0]      cfg_data,
	mbpt_in_if.sink                             in_ch,
	mbpt_out_if.source                          out_ch
);

	// configuration
	logic [mbpt_pkg::HIST_W-1:0]      pattern_q;
	logic [mbpt_pkg::PATTERN_MAX-1:0] care_q;
	logic [mbpt_pkg::LEN_W-1:0]       len_q;
	logic                             hex_q;
	logic [mbpt_pkg::TICK_W-1:0]      cool_q;

	// match state
	logic [mbpt_pkg::HIST_W-1:0]      hist_q;
	logic [mbpt_pkg::FILL_W-1:0]      fill_q;
	logic                             pending_q;
	logic [mbpt_pkg::AGE_W-1:0]       age_q;
	logic [mbpt_pkg::TICK_W-1:0]      ticks_q;

	// result register
	logic                             out_valid_q;
	logic                             seen_q;
	logic                             fire_q;

	logic                             accept;
	logic [mbpt_pkg::HIST_W-1:0]      hist_d;
	logic [mbpt_pkg::FILL_W-1:0]      fill_d;
	logic                             pending_d;
	logic [mbpt_pkg::AGE_W-1:0]       age_d;
	logic [mbpt_pkg::TICK_W-1:0]      ticks_d;
	logic                             seen_d;
	logic                             fire_d;
	logic [mbpt_pkg::HIST_W-1:0]      hist_shift;
	logic [mbpt_pkg::FILL_W-1:0]      fill_inc;
	logic [mbpt_pkg::LEN_W-1:0]       eff_len;
	logic [mbpt_pkg::IDX_W-1:0]       len_m1;
	logic [mbpt_pkg::AGE_W-1:0]       lookback;
	logic                             window_ok;
	logic                             byte_pending;
	logic [mbpt_pkg::AGE_W-1:0]       byte_age;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pattern_seen = seen_q;
	assign out_ch.fire         = fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= mbpt_pkg::PATTERN_RST;
			care_q    <= mbpt_pkg::CARE_RST;
			len_q     <= mbpt_pkg::LEN_RST;
			hex_q     <= 1'b0;
			cool_q    <= mbpt_pkg::COOLDOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbpt_pkg::REG_PATTERN:  pattern_q <= cfg_data;
				mbpt_pkg::REG_CARE:     care_q    <= cfg_data[mbpt_pkg::PATTERN_MAX-1:0];
				mbpt_pkg::REG_LENGTH:   len_q     <= cfg_data[mbpt_pkg::LEN_W-1:0];
				mbpt_pkg::REG_HEX:      hex_q     <= cfg_data[0];
				mbpt_pkg::REG_COOLDOWN: cool_q    <= cfg_data[mbpt_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// length 0 counts as 1, anything above the history depth as the depth
	always_comb begin
		if (len_q == '0)
			eff_len = mbpt_pkg::LEN_W'(1);
		else if (len_q > mbpt_pkg::LEN_W'(mbpt_pkg::PATTERN_MAX))
			eff_len = mbpt_pkg::LEN_W'(mbpt_pkg::PATTERN_MAX);
		else
			eff_len = len_q;
	end

	assign len_m1     = mbpt_pkg::IDX_W'(eff_len - mbpt_pkg::LEN_W'(1));
	assign lookback   = hex_q ? mbpt_pkg::HEX_LB : mbpt_pkg::TEXT_LB;
	assign hist_shift = {hist_q[mbpt_pkg::HIST_W-mbpt_pkg::BYTE_W-1:0], in_ch.rx_byte};
	assign fill_inc   = (fill_q < mbpt_pkg::FILL_MAX) ? fill_q + mbpt_pkg::FILL_W'(1) : fill_q;

	// pattern byte k is compared with the history byte len-1-k places back
	always_comb begin
		logic [mbpt_pkg::IDX_W-1:0]  back;
		logic [mbpt_pkg::BYTE_W-1:0] hb;
		logic [mbpt_pkg::BYTE_W-1:0] pb;
		window_ok = (mbpt_pkg::LEN_W'(fill_inc) >= eff_len);
		for (int k = 0; k < mbpt_pkg::PATTERN_MAX; k++) begin
			back = len_m1 - mbpt_pkg::IDX_W'(k);
			hb   = hist_shift[back*mbpt_pkg::BYTE_W +: mbpt_pkg::BYTE_W];
			pb   = pattern_q[k*mbpt_pkg::BYTE_W +: mbpt_pkg::BYTE_W];
			if (mbpt_pkg::IDX_W'(k) <= len_m1 && (!hex_q || care_q[k]) && hb != pb)
				window_ok = 1'b0;
		end
	end

	always_comb begin
		byte_pending = pending_q;
		byte_age     = age_q;
		if (window_ok) begin
			byte_pending = 1'b1;
			byte_age     = '0;
		end else if (pending_q) begin
			if (age_q >= lookback) begin
				byte_pending = 1'b0;
				byte_age     = '0;
			end else if (age_q != mbpt_pkg::AGE_MAX) begin
				byte_age = age_q + mbpt_pkg::AGE_W'(1);
			end
		end
	end

	always_comb begin
		hist_d    = hist_q;
		fill_d    = fill_q;
		pending_d = pending_q;
		age_d     = age_q;
		ticks_d   = ticks_q;
		seen_d    = pending_q;
		fire_d    = 1'b0;
		if (in_ch.req_type == mbpt_pkg::REQ_TICK) begin
			if (ticks_q != mbpt_pkg::TICK_MAX)
				ticks_d = ticks_q + mbpt_pkg::TICK_W'(1);
		end else begin
			hist_d    = hist_shift;
			fill_d    = fill_inc;
			pending_d = byte_pending;
			age_d     = byte_age;
			seen_d    = byte_pending;
			if (byte_pending && ticks_q >= cool_q) begin
				fire_d    = 1'b1;
				hist_d    = '0;
				fill_d    = '0;
				pending_d = 1'b0;
				age_d     = '0;
				ticks_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '0;
			fill_q    <= '0;
			pending_q <= 1'b0;
			age_q     <= '0;
			ticks_q   <= mbpt_pkg::TICK_MAX;
		end else if (accept) begin
			hist_q    <= hist_d;
			fill_q    <= fill_d;
			pending_q <= pending_d;
			age_q     <= age_d;
			ticks_q   <= ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seen_q <= seen_d;
			fire_q <= fire_d;
		end
	end

	a_fire_implies_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fire_q |-> seen_q)
		else $error("fire without pattern_seen");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fire_d |=> ticks_q == '0 && fill_q == '0 && !pending_q)
		else $error("fire did not clear history and cooldown");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mbpt_pkg::FILL_MAX)
		else $error("fill count beyond history depth");

	a_age_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> age_q == '0)
		else $error("match age running with no match pending");

	a_tick_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.req_type == mbpt_pkg::REQ_TICK |=> !fire_q && out_valid_q)
		else $error("tick request produced a fire");

endmodule
